// ===== rtl/loose_rfc3339_timestamp_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the loose timestamp parser
// Shared macros that wrap concurrent assertions on the block clock.
// ----------------------------------------------------------------------------
`ifndef LOOSE_RFC3339_TIMESTAMP_PARSER_DEFINES_SVH
`define LOOSE_RFC3339_TIMESTAMP_PARSER_DEFINES_SVH

// Checks a property on every rising clock edge while the reset is released.
`define LRTP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, also while the reset is held.
`define LRTP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/lrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Loose timestamp parser package
// Types, character codes, limits and the saturating digit accumulate function.
// ----------------------------------------------------------------------------
`default_nettype none

package lrtp_pkg;

    localparam int COUNT_MAX = 255;
    localparam int COUNT_W   = $clog2(COUNT_MAX + 1);

    localparam logic [30:0] ACC_MAX    = 31'h7FFF_FFFF;
    localparam logic [15:0] YEAR_MAX   = 16'hFFFF;
    localparam logic [7:0]  FCOUNT_MAX = 8'hFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [3:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SECOND,
        PH_FRAC,
        PH_TRAIL,
        PH_OFFH,
        PH_OFFM
    } t_phase;

    typedef enum logic [1:0] {
        RES_PEND,
        RES_OK,
        RES_BAD
    } t_res;

    typedef enum logic [1:0] {
        ZONE_LOCAL,
        ZONE_UTC,
        ZONE_PLUS,
        ZONE_MINUS
    } t_zone;

    typedef enum logic [1:0] {
        OUTC_INVALID,
        OUTC_TYPE1,
        OUTC_TYPE2
    } t_outcome;

    function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [3:0] d);
        logic [34:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(d);
        return (sum > 35'(ACC_MAX)) ? ACC_MAX : sum[30:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/loose_rfc3339_timestamp_parser.sv =====
// Output: a result is registered when the character that settles it is accepted.
// Throughput: one character per cycle unless stalled; a single parser update per character.
// A full output register that is not taken stalls the input side.
// Reset: synchronous, active low; clears the parser state and empties the output register.
// The parser state also returns to its reset values after every character marked last.
// ----------------------------------------------------------------------------
// Loose timestamp parser
// Recognizes a date, time, fraction and zone from a character stream and
// emits one checked result per string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "loose_rfc3339_timestamp_parser_defines.svh"

module loose_rfc3339_timestamp_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_last,
    input  wire logic [1:0]  i_prior_time_type,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_outcome,
    output logic [15:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [30:0]      o_secfrac,
    output logic [7:0]       o_secfrac_digits,
    output logic [1:0]       o_zone_kind,
    output logic [10:0]      o_offset_minutes,
    output logic [lrtp_pkg::COUNT_W-1:0] o_consumed
);
    import lrtp_pkg::*;

    t_phase             r_phase, n_phase;
    logic [30:0]        r_acc, n_acc;
    logic [15:0]        r_year, n_year;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_day, n_day;
    logic [4:0]         r_hour, n_hour;
    logic [5:0]         r_minute, n_minute;
    logic [5:0]         r_second, n_second;
    logic [30:0]        r_frac, n_frac;
    logic [7:0]         r_fcount, n_fcount;
    t_zone              r_zkind, n_zkind;
    logic [4:0]         r_zhour, n_zhour;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_given, n_given;
    logic [1:0]         r_prior, n_prior;

    logic               r_out_valid, n_out_valid;
    t_outcome           r_outcome, n_outcome;
    logic [15:0]        r_o_year, n_o_year;
    logic [3:0]         r_o_month, n_o_month;
    logic [4:0]         r_o_day, n_o_day;
    logic [4:0]         r_o_hour, n_o_hour;
    logic [5:0]         r_o_minute, n_o_minute;
    logic [5:0]         r_o_second, n_o_second;
    logic [30:0]        r_o_frac, n_o_frac;
    logic [7:0]         r_o_fcount, n_o_fcount;
    t_zone              r_o_zkind, n_o_zkind;
    logic [10:0]        r_o_offset, n_o_offset;
    logic [COUNT_W-1:0] r_o_count, n_o_count;

    logic               w_accept;
    logic               w_dig;
    logic [3:0]         w_d;
    logic [1:0]         w_prior;
    logic [30:0]        w_acc_sum;
    logic [30:0]        w_frac_sum;
    t_res               w_res;
    logic               w_emit;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_dig    = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);
    assign w_d      = w_dig ? 4'(i_char_in - CH_ZERO) : 4'd0;
    assign w_prior  = (r_count == '0) ? i_prior_time_type : r_prior;
    assign w_acc_sum  = add_digit(r_acc, w_d);
    assign w_frac_sum = add_digit(r_frac, w_d);
    assign w_emit   = w_accept && !r_given && (w_res != RES_PEND);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_frac   = r_frac;
        n_fcount = r_fcount;
        n_zkind  = r_zkind;
        n_zhour  = r_zhour;
        n_prior  = w_prior;
        n_count  = (r_count < COUNT_W'(COUNT_MAX)) ? r_count + 1'b1 : r_count;
        w_res    = RES_PEND;

        unique case (r_phase)
            PH_YEAR: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (i_char_in != CH_DASH) begin
                    w_res = RES_BAD;
                end else begin
                    n_year  = (r_acc > 31'(YEAR_MAX)) ? YEAR_MAX : r_acc[15:0];
                    n_acc   = '0;
                    n_phase = PH_MONTH;
                end
            end
            PH_MONTH: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc < 31'd1 || r_acc > 31'd12 || i_char_in != CH_DASH) begin
                    w_res = RES_BAD;
                end else begin
                    n_month = r_acc[3:0];
                    n_acc   = '0;
                    n_phase = PH_DAY;
                end
            end
            PH_DAY: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc < 31'd1 || r_acc > 31'd31 || i_char_in != CH_T) begin
                    w_res = RES_BAD;
                end else begin
                    n_day   = r_acc[4:0];
                    n_acc   = '0;
                    n_phase = PH_HOUR;
                end
            end
            PH_HOUR: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc > 31'd23 || i_char_in != CH_COLON) begin
                    w_res = RES_BAD;
                end else begin
                    n_hour  = r_acc[4:0];
                    n_acc   = '0;
                    n_phase = PH_MINUTE;
                end
            end
            PH_MINUTE: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc > 31'd59 || i_char_in != CH_COLON) begin
                    w_res = RES_BAD;
                end else begin
                    n_minute = r_acc[5:0];
                    n_acc    = '0;
                    n_phase  = PH_SECOND;
                end
            end
            PH_SECOND, PH_FRAC: begin
                if (w_dig && r_phase == PH_SECOND) begin
                    n_acc = w_acc_sum;
                end else if (w_dig) begin
                    n_frac   = w_frac_sum;
                    n_fcount = (r_fcount < FCOUNT_MAX) ? r_fcount + 1'b1 : r_fcount;
                end else if (r_phase == PH_SECOND && r_acc > 31'd60) begin
                    w_res = RES_BAD;
                end else begin
                    if (r_phase == PH_SECOND) begin
                        n_second = r_acc[5:0];
                        n_acc    = '0;
                    end
                    if (r_phase == PH_SECOND && i_char_in == CH_DOT) begin
                        n_phase = PH_FRAC;
                    end else if (i_char_in == CH_SPACE || i_char_in == CH_NUL) begin
                        n_zkind = ZONE_LOCAL;
                        w_res   = RES_OK;
                    end else if (i_char_in == CH_Z) begin
                        n_zkind = ZONE_UTC;
                        n_phase = PH_TRAIL;
                    end else if (i_char_in == CH_PLUS || i_char_in == CH_DASH) begin
                        n_zkind = (i_char_in == CH_PLUS) ? ZONE_PLUS : ZONE_MINUS;
                        n_acc   = '0;
                        n_phase = PH_OFFH;
                    end else begin
                        w_res = RES_BAD;
                    end
                end
            end
            PH_TRAIL: begin
                w_res = (i_char_in == CH_SPACE || i_char_in == CH_NUL) ? RES_OK : RES_BAD;
            end
            PH_OFFH: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc > 31'd23 || i_char_in != CH_COLON) begin
                    w_res = RES_BAD;
                end else begin
                    n_zhour = r_acc[4:0];
                    n_acc   = '0;
                    n_phase = PH_OFFM;
                end
            end
            PH_OFFM: begin
                if (w_dig) begin
                    n_acc = w_acc_sum;
                end else if (r_acc > 31'd59) begin
                    w_res = RES_BAD;
                end else begin
                    w_res = (i_char_in == CH_SPACE || i_char_in == CH_NUL) ? RES_OK : RES_BAD;
                end
            end
            default: begin
                w_res = RES_BAD;
            end
        endcase

        // The string ends early: settle what the parser has seen so far.
        if (w_res == RES_PEND && i_last) begin
            unique case (n_phase)
                PH_SECOND: begin
                    if (n_acc > 31'd60) begin
                        w_res = RES_BAD;
                    end else begin
                        n_second = n_acc[5:0];
                        n_acc    = '0;
                        n_zkind  = ZONE_LOCAL;
                        w_res    = RES_OK;
                    end
                end
                PH_FRAC: begin
                    n_zkind = ZONE_LOCAL;
                    w_res   = RES_OK;
                end
                PH_TRAIL: begin
                    w_res = RES_OK;
                end
                PH_OFFM: begin
                    w_res = (n_acc > 31'd59) ? RES_BAD : RES_OK;
                end
                default: begin
                    w_res = RES_BAD;
                end
            endcase
        end

        n_given = r_given || (w_res != RES_PEND);

        if (w_res == RES_OK) begin
            if (n_zkind != ZONE_LOCAL) begin
                n_outcome = OUTC_TYPE2;
            end else if (w_prior == 2'd0 || w_prior == 2'd1) begin
                n_outcome = OUTC_TYPE1;
            end else begin
                n_outcome = OUTC_TYPE2;
            end
            n_o_year   = n_year;
            n_o_month  = n_month;
            n_o_day    = n_day;
            n_o_hour   = n_hour;
            n_o_minute = n_minute;
            n_o_second = n_second;
            n_o_frac   = n_frac;
            n_o_fcount = n_fcount;
            n_o_zkind  = n_zkind;
            n_o_offset = (n_zkind == ZONE_PLUS || n_zkind == ZONE_MINUS)
                       ? 11'(n_zhour) * 11'd60 + 11'(n_acc[5:0]) : 11'd0;
            n_o_count  = n_count;
        end else begin
            n_outcome  = OUTC_INVALID;
            n_o_year   = '0;
            n_o_month  = '0;
            n_o_day    = '0;
            n_o_hour   = '0;
            n_o_minute = '0;
            n_o_second = '0;
            n_o_frac   = '0;
            n_o_fcount = '0;
            n_o_zkind  = ZONE_LOCAL;
            n_o_offset = '0;
            n_o_count  = '0;
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last)) begin
            r_phase  <= PH_YEAR;
            r_acc    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_frac   <= '0;
            r_fcount <= '0;
            r_zkind  <= ZONE_LOCAL;
            r_zhour  <= '0;
            r_count  <= '0;
            r_given  <= 1'b0;
            r_prior  <= '0;
        end else if (w_accept && !r_given) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_frac   <= n_frac;
            r_fcount <= n_fcount;
            r_zkind  <= n_zkind;
            r_zhour  <= n_zhour;
            r_count  <= n_count;
            r_given  <= n_given;
            r_prior  <= n_prior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_outcome  <= n_outcome;
            r_o_year   <= n_o_year;
            r_o_month  <= n_o_month;
            r_o_day    <= n_o_day;
            r_o_hour   <= n_o_hour;
            r_o_minute <= n_o_minute;
            r_o_second <= n_o_second;
            r_o_frac   <= n_o_frac;
            r_o_fcount <= n_o_fcount;
            r_o_zkind  <= n_o_zkind;
            r_o_offset <= n_o_offset;
            r_o_count  <= n_o_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_year           = r_o_year;
    assign o_month          = r_o_month;
    assign o_day            = r_o_day;
    assign o_hour           = r_o_hour;
    assign o_minute         = r_o_minute;
    assign o_second         = r_o_second;
    assign o_secfrac        = r_o_frac;
    assign o_secfrac_digits = r_o_fcount;
    assign o_zone_kind      = r_o_zkind;
    assign o_offset_minutes = r_o_offset;
    assign o_consumed       = r_o_count;

    `LRTP_ASSERT_ALWAYS(a_reset_empties_output, !i_rst_n |=> !o_valid, "Output valid after reset.")
    `LRTP_ASSERT(a_consumed_matches_outcome, o_valid |-> ((o_outcome == OUTC_INVALID) == (o_consumed == '0)), "Consumed count disagrees with outcome.")
    `LRTP_ASSERT(a_one_result_per_string, (w_emit && !i_last) |=> (r_given && !w_emit), "A second result was produced for one string.")
    `LRTP_ASSERT(a_zone_fields_agree, (o_valid && o_zone_kind != ZONE_LOCAL) |-> (o_outcome == OUTC_TYPE2), "Zoned result without time type 2.")
    `LRTP_ASSERT(a_valid_fields_in_range, (o_valid && o_outcome != OUTC_INVALID) |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_hour <= 5'd23 && o_offset_minutes <= 11'd1439), "Valid result with a field out of range.")

endmodule

`default_nettype wire
